// ===== rtl/quaternion_gyro_integrator_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion gyro integrator
// Clock and reset are taken from the enclosing module (i_clk, i_rst_n).
// ---------------------------------------------------------------------------
`ifndef QUATERNION_GYRO_INTEGRATOR_DEFINES_SVH
`define QUATERNION_GYRO_INTEGRATOR_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define QGI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("qgi: check failed");

// Check that a condition never holds.
`define QGI_NEVER(lbl, expr) `QGI_ASSERT(lbl, !(expr))

`endif

// ===== rtl/qgi_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qgi_pkg
// Widths, datapath op codes, controller/datapath structs and the
// Omega(p,q,r) term table for the quaternion gyro integrator.
// ---------------------------------------------------------------------------
package qgi_pkg;

    localparam int QUAT_W      = 32;
    localparam int RATE_W      = 16;
    localparam int DT_W        = 24;
    localparam int SUM_SHIFT   = 8;
    localparam int FINAL_SHIFT = (RATE_W - 4) + DT_W + 1 - SUM_SHIFT;
    localparam int OPA_W       = 33;
    localparam int PROD_W      = 2 * OPA_W;
    localparam int T_W         = 40;
    localparam int T_LO_W      = 20;
    localparam int DELTA_W     = 36;
    localparam int N_W         = 40;
    localparam int MAG_W       = 39;
    localparam int WIN_W       = 31;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;
    localparam int SQ_REM_W    = 35;
    localparam int SQ_STEPS    = 32;
    localparam int QUO_W       = 31;
    localparam int NUM_W       = 62;
    localparam int CNT_W       = 5;

    localparam logic [DT_W-1:0]          DT_RESET = 24'd16777;
    localparam logic signed [QUAT_W-1:0] Q_ONE    = 32'sh4000_0000;
    localparam logic [QUO_W-1:0]         QUO_ONE  = 31'h4000_0000;

    localparam logic [1:0] RATE_P = 2'd0;
    localparam logic [1:0] RATE_Q = 2'd1;
    localparam logic [1:0] RATE_R = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_TERM,
        OP_ACC_TERM,
        OP_ROUND,
        OP_MUL_LO,
        OP_ACC_LO,
        OP_MUL_HI,
        OP_ACC_HI,
        OP_UPDATE,
        OP_MAG,
        OP_SCALE,
        OP_MUL_SQ,
        OP_ACC_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] comp;
        logic [1:0] term;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic over;
        logic under;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic [1:0] rsel;
        logic [1:0] asel;
        logic       neg;
    } t_term;

    // One rate-times-component term of dq = Omega(p,q,r) * q.
    function automatic t_term term_sel(input logic [1:0] comp, input logic [1:0] term);
        t_term t;
        unique case ({comp, term})
            4'b00_00: t = '{RATE_P, 2'd1, 1'b1};
            4'b00_01: t = '{RATE_Q, 2'd2, 1'b1};
            4'b00_10: t = '{RATE_R, 2'd3, 1'b1};
            4'b01_00: t = '{RATE_P, 2'd0, 1'b0};
            4'b01_01: t = '{RATE_R, 2'd2, 1'b0};
            4'b01_10: t = '{RATE_Q, 2'd3, 1'b1};
            4'b10_00: t = '{RATE_Q, 2'd0, 1'b0};
            4'b10_01: t = '{RATE_R, 2'd1, 1'b1};
            4'b10_10: t = '{RATE_P, 2'd3, 1'b0};
            4'b11_00: t = '{RATE_R, 2'd0, 1'b0};
            4'b11_01: t = '{RATE_Q, 2'd1, 1'b0};
            4'b11_10: t = '{RATE_P, 2'd2, 1'b1};
            default:  t = '{RATE_P, 2'd0, 1'b0};
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/qgi_ctrl.sv =====
`timescale 1ns / 1ps
`include "quaternion_gyro_integrator_defines.svh"
// ---------------------------------------------------------------------------
// qgi_ctrl
// Sequencer: steps the datapath through integration, scaling, square root,
// division and commit, one command per cycle except while the commit waits for the output register.
// ---------------------------------------------------------------------------
module qgi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  qgi_pkg::t_stat i_stat,
    output qgi_pkg::t_cmd  o_cmd
);
    import qgi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_ACC, S_ROUND, S_MLO, S_ALO, S_MHI, S_AHI, S_UPD,
        S_MAG, S_SCALE, S_SQM, S_SQA, S_SQI, S_SQRT, S_DINI, S_DIV, S_DDONE,
        S_COMMIT
    } t_state;

    t_state           r_state;
    logic [1:0]       r_comp;
    logic [1:0]       r_term;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.comp = r_comp;
        o_cmd.term = r_term;
        unique case (r_state)
            S_IDLE:   o_cmd.op = i_valid ? OP_LOAD : OP_NONE;
            S_MUL:    o_cmd.op = OP_MUL_TERM;
            S_ACC:    o_cmd.op = OP_ACC_TERM;
            S_ROUND:  o_cmd.op = OP_ROUND;
            S_MLO:    o_cmd.op = OP_MUL_LO;
            S_ALO:    o_cmd.op = OP_ACC_LO;
            S_MHI:    o_cmd.op = OP_MUL_HI;
            S_AHI:    o_cmd.op = OP_ACC_HI;
            S_UPD:    o_cmd.op = OP_UPDATE;
            S_MAG:    o_cmd.op = OP_MAG;
            S_SCALE:  o_cmd.op = OP_SCALE;
            S_SQM:    o_cmd.op = OP_MUL_SQ;
            S_SQA:    o_cmd.op = OP_ACC_SQ;
            S_SQI:    o_cmd.op = OP_SQRT_INIT;
            S_SQRT:   o_cmd.op = OP_SQRT_STEP;
            S_DINI:   o_cmd.op = OP_DIV_INIT;
            S_DIV:    o_cmd.op = OP_DIV_STEP;
            S_DDONE:  o_cmd.op = OP_DIV_DONE;
            S_COMMIT: o_cmd.op = i_stat.out_busy ? OP_NONE : OP_COMMIT;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_comp  <= '0;
            r_term  <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_comp  <= '0;
                        r_term  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    if (r_term == 2'd2) begin
                        r_term  <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_term  <= r_term + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_ROUND: r_state <= S_MLO;
                S_MLO:   r_state <= S_ALO;
                S_ALO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_AHI;
                S_AHI:   r_state <= S_UPD;
                S_UPD: begin
                    if (r_comp == 2'd3) begin
                        r_comp  <= '0;
                        r_state <= S_MAG;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_MAG: r_state <= S_SCALE;
                S_SCALE: begin
                    if (i_stat.zero) begin
                        r_state <= S_COMMIT;
                    end else if (!i_stat.over && !i_stat.under) begin
                        r_comp  <= '0;
                        r_state <= S_SQM;
                    end
                end
                S_SQM: r_state <= S_SQA;
                S_SQA: begin
                    if (r_comp == 2'd3) begin
                        r_comp  <= '0;
                        r_state <= S_SQI;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_SQM;
                    end
                end
                S_SQI: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                        r_comp  <= '0;
                        r_state <= S_DINI;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DINI: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        r_state <= S_DDONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DDONE: begin
                    if (r_comp == 2'd3) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_DINI;
                    end
                end
                S_COMMIT: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `QGI_ASSERT(a_busy_after_accept, (r_state == S_IDLE && i_valid) |=> !o_ready)
    `QGI_ASSERT(a_commit_when_free, (o_cmd.op == OP_COMMIT) |-> !i_stat.out_busy)
    `QGI_ASSERT(a_sqrt_length, (r_state == S_SQRT && r_cnt == CNT_W'(SQ_STEPS - 1)) |=> (r_state == S_DINI))
    `QGI_NEVER(a_div_count_range, r_state == S_DIV && r_cnt > CNT_W'(QUO_W - 1))

endmodule

// ===== rtl/qgi_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qgi_datapath
// Attitude state, shared multiplier, accumulator, scaler, bit-pair square
// root, restoring divider and output register.
// ---------------------------------------------------------------------------
module qgi_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  qgi_pkg::t_cmd                      i_cmd,
    output qgi_pkg::t_stat                     o_stat,
    input  logic signed [qgi_pkg::RATE_W-1:0]  i_rate_x,
    input  logic signed [qgi_pkg::RATE_W-1:0]  i_rate_y,
    input  logic signed [qgi_pkg::RATE_W-1:0]  i_rate_z,
    input  logic                               i_cfg_valid,
    input  logic [qgi_pkg::DT_W-1:0]           i_time_step,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_w,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_x,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_y,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_z,
    output logic                               o_norm_fault
);
    import qgi_pkg::*;

    localparam int QFRAC_BITS = QUAT_W - 2;

    logic signed [RATE_W-1:0] r_rate [3];
    logic [DT_W-1:0]          r_dt;
    logic signed [QUAT_W-1:0] r_att  [4];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [T_W-1:0]    r_t;
    logic signed [N_W-1:0]    r_n    [4];
    logic [MAG_W-1:0]         r_mag  [4];
    logic                     r_neg  [4];
    logic                     r_fault;
    logic [SQ_W-1:0]          r_sumsq;
    logic [SQ_W-1:0]          r_rad;
    logic [SQ_REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [ROOT_W-1:0]        r_drem;
    logic [QUO_W-1:0]         r_dlow;
    logic [QUO_W-1:0]         r_quo;
    logic signed [QUAT_W-1:0] r_res  [4];
    logic signed [QUAT_W-1:0] r_out  [4];
    logic                     r_out_fault;
    logic                     r_out_valid;

    t_term                    tm;
    logic [1:0]               att_idx;
    logic signed [QUAT_W-1:0] att_val;
    logic signed [RATE_W-1:0] rate_val;
    logic [MAG_W-1:0]         mag_val;
    logic signed [OPA_W-1:0]  opa;
    logic signed [OPA_W-1:0]  opb;
    logic [MAG_W-1:0]         orm;
    logic signed [PROD_W-1:0] rnd;
    logic signed [DELTA_W-1:0] delta;
    logic [SQ_REM_W-1:0]      sq_rem2;
    logic [SQ_REM_W-1:0]      sq_trial;
    logic [NUM_W-1:0]         num;
    logic [ROOT_W:0]          dv_rem2;
    logic [QUO_W-1:0]         quo_sat;

    assign tm      = term_sel(i_cmd.comp, i_cmd.term);
    assign att_idx = (i_cmd.op == OP_UPDATE) ? i_cmd.comp : tm.asel;
    assign att_val = r_att[att_idx];
    assign mag_val = r_mag[i_cmd.comp];

    always_comb begin
        case (tm.rsel)
            RATE_Q:  rate_val = r_rate[1];
            RATE_R:  rate_val = r_rate[2];
            default: rate_val = r_rate[0];
        endcase
    end

    // Operand select for the one shared multiplier.
    always_comb begin
        case (i_cmd.op)
            OP_MUL_TERM: begin
                opa = {{(OPA_W-QUAT_W){att_val[QUAT_W-1]}}, att_val};
                opb = {{(OPA_W-RATE_W){rate_val[RATE_W-1]}}, rate_val};
            end
            OP_MUL_LO: begin
                opa = {{(OPA_W-T_LO_W){1'b0}}, r_t[T_LO_W-1:0]};
                opb = {{(OPA_W-DT_W){1'b0}}, r_dt};
            end
            OP_MUL_HI: begin
                opa = {{(OPA_W-T_W+T_LO_W){r_t[T_W-1]}}, r_t[T_W-1:T_LO_W]};
                opb = {{(OPA_W-DT_W){1'b0}}, r_dt};
            end
            OP_MUL_SQ: begin
                opa = {{(OPA_W-WIN_W){1'b0}}, mag_val[WIN_W-1:0]};
                opb = {{(OPA_W-WIN_W){1'b0}}, mag_val[WIN_W-1:0]};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // Common exponent of the four magnitudes follows from their OR.
    assign orm            = r_mag[0] | r_mag[1] | r_mag[2] | r_mag[3];
    assign o_stat.zero     = (orm == '0);
    assign o_stat.over     = |orm[MAG_W-1:WIN_W];
    assign o_stat.under    = ~|orm[WIN_W-1:WIN_W-2];
    assign o_stat.out_busy = r_out_valid && !i_ready;

    always_comb begin
        if (i_cmd.op == OP_ROUND) begin
            rnd = r_acc + (PROD_W'(1) <<< (SUM_SHIFT - 1));
        end else begin
            rnd = r_acc + (PROD_W'(1) <<< (FINAL_SHIFT - 1));
        end
    end
    assign delta = rnd[FINAL_SHIFT+DELTA_W-1:FINAL_SHIFT];

    assign sq_rem2  = {r_rem[SQ_REM_W-3:0], r_rad[SQ_W-1:SQ_W-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign num      = {1'b0, mag_val[WIN_W-1:0], {QFRAC_BITS{1'b0}}}
                    + {{(NUM_W-ROOT_W+1){1'b0}}, r_root[ROOT_W-1:1]};
    assign dv_rem2  = {r_drem, r_dlow[QUO_W-1]};
    assign quo_sat  = (r_quo > QUO_ONE) ? QUO_ONE : r_quo;

    always_ff @(posedge i_clk) begin
        r_prod <= opa * opb;
    end

    // Arithmetic registers: no reset needed.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_rate[0] <= i_rate_x;
                r_rate[1] <= i_rate_y;
                r_rate[2] <= i_rate_z;
                r_acc     <= '0;
            end
            OP_ACC_TERM: r_acc <= tm.neg ? r_acc - r_prod : r_acc + r_prod;
            OP_ROUND: begin
                r_t   <= rnd[SUM_SHIFT+T_W-1:SUM_SHIFT];
                r_acc <= '0;
            end
            OP_ACC_LO: r_acc <= r_acc + r_prod;
            OP_ACC_HI: r_acc <= r_acc + (r_prod <<< T_LO_W);
            OP_UPDATE: begin
                r_n[i_cmd.comp] <= {{(N_W-QUAT_W){att_val[QUAT_W-1]}}, att_val}
                                 + {{(N_W-DELTA_W){delta[DELTA_W-1]}}, delta};
                r_acc <= '0;
            end
            OP_MAG: begin
                for (int i = 0; i < 4; i++) begin
                    r_neg[i] <= r_n[i][N_W-1];
                    r_mag[i] <= r_n[i][N_W-1] ? MAG_W'(-r_n[i]) : MAG_W'(r_n[i]);
                end
                r_sumsq <= '0;
                r_fault <= 1'b0;
            end
            OP_SCALE: begin
                if (o_stat.zero) begin
                    r_fault <= 1'b1;
                end else if (o_stat.over) begin
                    for (int i = 0; i < 4; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (o_stat.under) begin
                    for (int i = 0; i < 4; i++) r_mag[i] <= r_mag[i] << 1;
                end
            end
            OP_ACC_SQ: r_sumsq <= r_sumsq + r_prod[SQ_W-1:0];
            OP_SQRT_INIT: begin
                r_rad  <= r_sumsq;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT_STEP: begin
                r_rad <= r_rad << 2;
                if (sq_rem2 >= sq_trial) begin
                    r_rem  <= sq_rem2 - sq_trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem2;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            OP_DIV_INIT: begin
                r_drem <= {1'b0, num[NUM_W-1:QUO_W]};
                r_dlow <= num[QUO_W-1:0];
                r_quo  <= '0;
            end
            OP_DIV_STEP: begin
                r_dlow <= r_dlow << 1;
                if (dv_rem2 >= {1'b0, r_root}) begin
                    r_drem <= ROOT_W'(dv_rem2 - {1'b0, r_root});
                    r_quo  <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_drem <= dv_rem2[ROOT_W-1:0];
                    r_quo  <= {r_quo[QUO_W-2:0], 1'b0};
                end
            end
            OP_DIV_DONE: begin
                r_res[i_cmd.comp] <= r_neg[i_cmd.comp]
                                   ? -QUAT_W'(quo_sat) : QUAT_W'(quo_sat);
            end
            default: ;
        endcase
    end

    // Attitude, time step and output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt        <= DT_RESET;
            r_att[0]    <= Q_ONE;
            r_att[1]    <= '0;
            r_att[2]    <= '0;
            r_att[3]    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dt <= i_time_step;
            end
            if (i_cmd.op == OP_COMMIT) begin
                for (int i = 0; i < 4; i++) begin
                    if (r_fault) begin
                        r_att[i] <= (i == 0) ? Q_ONE : '0;
                        r_out[i] <= (i == 0) ? Q_ONE : '0;
                    end else begin
                        r_att[i] <= r_res[i];
                        r_out[i] <= r_res[i];
                    end
                end
                r_out_fault <= r_fault;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_q_w        = r_out[0];
    assign o_q_x        = r_out[1];
    assign o_q_y        = r_out[2];
    assign o_q_z        = r_out[3];
    assign o_norm_fault = r_out_fault;

endmodule

// ===== rtl/quaternion_gyro_integrator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_gyro_integrator
// Euler integration of body rates into a unit attitude quaternion, with
// renormalisation after every sample.
//
//   channel   direction  handshake               word
//   input     in         i_valid / o_ready       i_rate_x, i_rate_y, i_rate_z
//   config    in         i_cfg_valid / o_cfg_ready  i_time_step
//   result    out        o_valid / i_ready       o_q_w..o_q_z, o_norm_fault
//
// One sample passes through these steps in order: taking it, the twelve rate
// terms and the dt products on the one shared multiplier, the magnitudes, the
// exponent search, the squares, the bit-pair square root, four 31-step
// restoring divisions and the commit.
// A zero norm skips root and divide.
// Reset (synchronous, active low) sets the attitude to identity and the time
// step to 16777; there is no clearing pass.
// A new sample is taken while the previous result still waits; the commit of
// the next result holds until the waiting word is taken. Config is always
// ready and must only be written while idle.
// ---------------------------------------------------------------------------
module quaternion_gyro_integrator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [qgi_pkg::RATE_W-1:0]  i_rate_x,
    input  logic signed [qgi_pkg::RATE_W-1:0]  i_rate_y,
    input  logic signed [qgi_pkg::RATE_W-1:0]  i_rate_z,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [qgi_pkg::DT_W-1:0]           i_time_step,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_w,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_x,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_y,
    output logic signed [qgi_pkg::QUAT_W-1:0]  o_q_z,
    output logic                               o_norm_fault
);
    import qgi_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Time step register takes a word on any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer: one datapath command per cycle, except while the commit waits.
    qgi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Arithmetic, attitude state and output word.
    qgi_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_rate_x     (i_rate_x),
        .i_rate_y     (i_rate_y),
        .i_rate_z     (i_rate_z),
        .i_cfg_valid  (i_cfg_valid),
        .i_time_step  (i_time_step),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_q_w        (o_q_w),
        .o_q_x        (o_q_x),
        .o_q_y        (o_q_y),
        .o_q_z        (o_q_z),
        .o_norm_fault (o_norm_fault)
    );

endmodule

// ===== verif/quaternion_gyro_integrator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_gyro_integrator_tb
// Self-checking bench for the quaternion gyro integrator.
//
// Each accepted gyro sample is run through a local fixed-point model of the
// Euler step and the renormalisation. The expected quaternion word is queued
// and compared field by field with every word taken from the result channel.
// Both channels idle at random, with one long stretch at full rate. The time
// step is rewritten only between phases, once the block has drained.
// ---------------------------------------------------------------------------
module quaternion_gyro_integrator_tb;

    import qgi_pkg::*;

    typedef struct {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic                     fault;
    } t_att_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic signed [RATE_W-1:0]  i_rate_x = '0;
    logic signed [RATE_W-1:0]  i_rate_y = '0;
    logic signed [RATE_W-1:0]  i_rate_z = '0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [DT_W-1:0]           i_time_step = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [QUAT_W-1:0]  o_q_w, o_q_x, o_q_y, o_q_z;
    logic                      o_norm_fault;

    // Model state: attitude in Q1.30 and the time step in Q0.24.
    longint          att_q [4];
    longint unsigned dt_model;

    t_att_word pending_att [$];
    int        fail_count = 0;
    bit        full_rate  = 1'b0;   // hold both sides at full rate when set

    always #1 i_clk = ~i_clk;

    quaternion_gyro_integrator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_rate_x     (i_rate_x),
        .i_rate_y     (i_rate_y),
        .i_rate_z     (i_rate_z),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_time_step  (i_time_step),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_q_w        (o_q_w),
        .o_q_x        (o_q_x),
        .o_q_y        (o_q_y),
        .o_q_z        (o_q_z),
        .o_norm_fault (o_norm_fault)
    );

    // -----------------------------------------------------------------------
    // Fixed-point model of one integration step
    // -----------------------------------------------------------------------
    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void set_identity();
        att_q[0] = longint'(1) <<< (QUAT_W - 2);
        att_q[1] = 0;
        att_q[2] = 0;
        att_q[3] = 0;
    endfunction

    // Advance the model attitude by one gyro sample and return the word.
    function automatic t_att_word integrate_sample(input logic signed [RATE_W-1:0] rx,
                                                   input logic signed [RATE_W-1:0] ry,
                                                   input logic signed [RATE_W-1:0] rz);
        longint          p, q, r, a0, a1, a2, a3;
        longint          s [4];
        longint          n [4];
        longint unsigned mag [4];
        longint unsigned maxm, sumsq, nrm, o;
        int              left, right;
        t_att_word       res;
        p = rx; q = ry; r = rz;
        a0 = att_q[0]; a1 = att_q[1]; a2 = att_q[2]; a3 = att_q[3];
        s[0] = -p * a1 - q * a2 - r * a3;
        s[1] =  p * a0 + r * a2 - q * a3;
        s[2] =  q * a0 - r * a1 + p * a3;
        s[3] =  r * a0 + q * a1 - p * a2;
        maxm = 0;
        for (int i = 0; i < 4; i++) begin
            n[i]   = att_q[i] + rnd_shift(rnd_shift(s[i], SUM_SHIFT) * longint'(dt_model),
                                          FINAL_SHIFT);
            mag[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
            if (mag[i] > maxm) maxm = mag[i];
        end
        res.fault = (maxm == 0);
        if (res.fault) begin
            set_identity();
        end else begin
            left = 0; right = 0;
            while ((maxm >> right) >= (64'd1 << 31)) right++;
            while ((maxm << left) < (64'd1 << 29)) left++;
            sumsq = 0;
            for (int i = 0; i < 4; i++) begin
                mag[i] = (mag[i] >> right) << left;
                sumsq  = sumsq + mag[i] * mag[i];
            end
            nrm = int_sqrt(sumsq);
            for (int i = 0; i < 4; i++) begin
                o = ((mag[i] << (QUAT_W - 2)) + (nrm >> 1)) / nrm;
                if (o > (64'd1 << (QUAT_W - 2))) o = 64'd1 << (QUAT_W - 2);
                att_q[i] = (n[i] < 0) ? -longint'(o) : longint'(o);
            end
        end
        res.w = att_q[0][QUAT_W-1:0];
        res.x = att_q[1][QUAT_W-1:0];
        res.y = att_q[2][QUAT_W-1:0];
        res.z = att_q[3][QUAT_W-1:0];
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= full_rate ? 1'b1 : ($urandom_range(99) >= 32);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Sample between edges: a word seen with valid and ready here is taken
    // at the next rising edge.
    always @(negedge i_clk) begin
        t_att_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_att.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = pending_att.pop_front();
                if (o_q_w !== want.w) report_mismatch("q_w", o_q_w, want.w);
                if (o_q_x !== want.x) report_mismatch("q_x", o_q_x, want.x);
                if (o_q_y !== want.y) report_mismatch("q_y", o_q_y, want.y);
                if (o_q_z !== want.z) report_mismatch("q_z", o_q_z, want.z);
                if (o_norm_fault !== want.fault)
                    report_mismatch("norm_fault", o_norm_fault, want.fault);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------
    // Offer one sample; idle first at random, hold it until taken.
    task automatic send_sample(input logic [RATE_W-1:0] rx, input logic [RATE_W-1:0] ry,
                               input logic [RATE_W-1:0] rz);
        while (!full_rate && $urandom_range(99) < 32) @(posedge i_clk);
        i_valid  <= 1'b1;
        i_rate_x <= rx;
        i_rate_y <= ry;
        i_rate_z <= rz;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        pending_att.push_back(integrate_sample(rx, ry, rz));
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold until every expected word has come, then let the block settle.
    task automatic wait_drained();
        while (pending_att.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_time_step(input logic [DT_W-1:0] dt);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_time_step <= dt;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        dt_model = dt;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_samples(input int count, input int low_rate);
        logic [RATE_W-1:0] rv [3];
        for (int k = 0; k < count; k++) begin
            for (int a = 0; a < 3; a++) begin
                if (low_rate != 0 && $urandom_range(3) != 0)
                    rv[a] = RATE_W'($signed($urandom_range(8191)) - 4096);
                else
                    rv[a] = RATE_W'($urandom());
            end
            send_sample(rv[0], rv[1], rv[2]);
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_reset_time_step();
        // The reset time step applies before any write.
        send_sample(16'sd4096, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd4096, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd4096);
        send_sample(16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_rate_extremes();
        write_time_step(24'hFF_FFFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7FFF, 16'h0000);
        send_sample(16'hFFFF, 16'h0001, 16'h8000);
        send_sample(16'h7FFF, 16'h8000, 16'hFFFF);
        send_sample(16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_time_step_extremes();
        // Zero step: only renormalise.
        write_time_step(24'd0);
        send_sample(16'h7FFF, 16'h8000, 16'h1234);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        write_time_step(24'd1);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h0001, 16'h7FFF);
        write_time_step(24'h80_0000);
        send_sample(16'h4000, 16'hC000, 16'h2000);
        send_sample(16'h8000, 16'h8000, 16'h7FFF);
    endtask

    task automatic test_random_phases();
        logic [DT_W-1:0] steps [8];
        steps = '{24'd16777, 24'hFF_FFFF, 24'd0, 24'd1, 24'h00_1000, 24'h40_0000,
                  24'hAA_5555, 24'h55_AAAA};
        for (int ph = 0; ph < 8; ph++) begin
            write_time_step(steps[ph]);
            full_rate = (ph == 3);
            random_samples(245, ph % 2);
        end
        full_rate = 1'b0;
    endtask

    task automatic test_drain_pause();
        write_time_step(DT_W'($urandom()));
        for (int k = 0; k < 10; k++) begin
            random_samples(3, 0);
            // Pause until the block has caught up completely.
            while (pending_att.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        dt_model = DT_RESET;
        set_identity();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_time_step();
        test_rate_extremes();
        test_time_step_extremes();
        test_random_phases();
        test_drain_pause();
        wait_drained();
        if (fail_count == 0 && pending_att.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
